// ===== design/pdu_pkg.sv =====
// ----------------------------------------------------------------------------
// pdu_pkg
// Shared constants and types of the polyline densify unit: parameter
// defaults, the controller state type and the command/status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package pdu_pkg;

  // Parameter defaults
  localparam int unsigned COORD_BITS_DEF = 32;
  localparam int unsigned MAX_INSERT_DEF = 63;

  // Spacing register
  localparam int unsigned SPC_W     = 24;
  localparam logic [SPC_W-1:0] SPC_RESET = 24'd256;

  // Insert count width (cap is at most 63)
  localparam int unsigned N_W = 6;

  // Controller states
  typedef enum logic [4:0] {
    S_IDLE,
    S_DECIDE,
    S_SQ_SETUP,
    S_SQ_STEP,
    S_SQRT_INIT,
    S_SQRT_STEP,
    S_N_CHK,
    S_NDIV_STEP,
    S_NSET,
    S_PT_CHK,
    S_PT_SETUP,
    S_PT_MUL,
    S_PT_DIVI,
    S_PT_DIV,
    S_PT_STORE,
    S_EMIT_PT,
    S_EMIT_VTX
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic       load_in;
    logic       delta;
    logic       sq_setup;
    logic       sq_clear;
    logic       mul_step;
    logic       sqrt_init;
    logic       sqrt_step;
    logic       ndiv_init;
    logic       div_step;
    logic       nset;
    logic       m_adv;
    logic       pt_setup;
    logic       pt_div_init;
    logic       pt_store;
    logic       emit_pt;
    logic       emit_vtx;
    logic [1:0] axis;
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic           first;
    logic           skip_div;
    logic           out_free;
    logic [N_W-1:0] n;
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== design/polyline_densify_unit.sv =====
// The first vertex of a line is passed straight to the output. Other vertices first
// run the shared bit-serial multiplier and root, and the divider unless the segment or
// the spacing has zero length; each inserted point runs the multiplier and divider
// once per axis. One vertex is in work at a time; output stalls hold it up.
// Reset clears the previous-vertex flag, output valid and sets spacing to 256 (unsigned, in coordinate units).
// ----------------------------------------------------------------------------
// polyline_densify_unit
// Densifies a 3D polyline at a fixed interval: inserts points along each
// segment at whole multiples of the spacing, then passes the vertex.
// ----------------------------------------------------------------------------
`default_nettype none

module polyline_densify_unit #(
  parameter int unsigned COORD_BITS = pdu_pkg::COORD_BITS_DEF,
  parameter int unsigned MAX_INSERT = pdu_pkg::MAX_INSERT_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic signed [COORD_BITS-1:0] in_x_i,
  input  wire logic signed [COORD_BITS-1:0] in_y_i,
  input  wire logic signed [COORD_BITS-1:0] in_z_i,
  input  wire logic                         line_start_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic signed [COORD_BITS-1:0]      out_x_o,
  output logic signed [COORD_BITS-1:0]      out_y_o,
  output logic signed [COORD_BITS-1:0]      out_z_o,
  output logic                              inserted_o,
  output logic                              capped_o,
  output logic                              run_end_o,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [pdu_pkg::SPC_W-1:0]    cfg_data_i
);

  pdu_pkg::dp_cmd_t cmd;
  pdu_pkg::dp_sts_t sts;

  // Spacing write is always taken
  assign cfg_ready_o = 1'b1;

  pdu_ctrl #(
    .COORD_BITS (COORD_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  pdu_dpath #(
    .COORD_BITS (COORD_BITS),
    .MAX_INSERT (MAX_INSERT)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_x_i       (in_x_i),
    .in_y_i       (in_y_i),
    .in_z_i       (in_z_i),
    .line_start_i (line_start_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .out_x_o      (out_x_o),
    .out_y_o      (out_y_o),
    .out_z_o      (out_z_o),
    .inserted_o   (inserted_o),
    .capped_o     (capped_o),
    .run_end_o    (run_end_o)
  );

endmodule

`default_nettype wire

// ===== design/pdu_ctrl.sv =====
// ----------------------------------------------------------------------------
// pdu_ctrl
// Sequencer of the densify unit: steps the shared multiplier, square root
// and divider of the datapath through one vertex and its inserted points.
// ----------------------------------------------------------------------------
`default_nettype none

module pdu_ctrl #(
  parameter int unsigned COORD_BITS = pdu_pkg::COORD_BITS_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  output pdu_pkg::dp_cmd_t      cmd_o,
  input  pdu_pkg::dp_sts_t      sts_i
);

  localparam int unsigned W  = COORD_BITS + 1;
  localparam int unsigned CW = $clog2(W + 2);
  localparam logic [CW-1:0] MUL_LAST  = CW'(W);
  localparam logic [CW-1:0] ITER_LAST = CW'(W - 1);
  localparam logic [1:0]    AXIS_LAST = 2'd2;

  pdu_pkg::state_e state_q, state_d;
  logic [CW-1:0]           cnt_q, cnt_d;
  logic [1:0]              axis_q, axis_d;
  logic [pdu_pkg::N_W-1:0] j_q, j_d;

  // State and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pdu_pkg::S_IDLE;
      cnt_q   <= '0;
      axis_q  <= '0;
      j_q     <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      axis_q  <= axis_d;
      j_q     <= j_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q + 1'b1;
    axis_d  = axis_q;
    j_d     = j_q;
    case (state_q)
      pdu_pkg::S_IDLE: begin
        j_d = '0;
        if (in_valid_i) state_d = pdu_pkg::S_DECIDE;
      end
      pdu_pkg::S_DECIDE: begin
        axis_d  = '0;
        state_d = sts_i.first ? pdu_pkg::S_EMIT_VTX : pdu_pkg::S_SQ_SETUP;
      end
      pdu_pkg::S_SQ_SETUP: begin
        cnt_d   = '0;
        state_d = pdu_pkg::S_SQ_STEP;
      end
      pdu_pkg::S_SQ_STEP: begin
        if (cnt_q == MUL_LAST) begin
          if (axis_q == AXIS_LAST) begin
            state_d = pdu_pkg::S_SQRT_INIT;
          end else begin
            axis_d  = axis_q + 1'b1;
            state_d = pdu_pkg::S_SQ_SETUP;
          end
        end
      end
      pdu_pkg::S_SQRT_INIT: begin
        cnt_d   = '0;
        state_d = pdu_pkg::S_SQRT_STEP;
      end
      pdu_pkg::S_SQRT_STEP: begin
        if (cnt_q == ITER_LAST) state_d = pdu_pkg::S_N_CHK;
      end
      pdu_pkg::S_N_CHK: begin
        cnt_d   = '0;
        state_d = sts_i.skip_div ? pdu_pkg::S_PT_CHK : pdu_pkg::S_NDIV_STEP;
      end
      pdu_pkg::S_NDIV_STEP: begin
        if (cnt_q == ITER_LAST) state_d = pdu_pkg::S_NSET;
      end
      pdu_pkg::S_NSET: begin
        state_d = pdu_pkg::S_PT_CHK;
      end
      pdu_pkg::S_PT_CHK: begin
        if (j_q == sts_i.n) begin
          state_d = pdu_pkg::S_EMIT_VTX;
        end else begin
          j_d     = j_q + 1'b1;
          axis_d  = '0;
          state_d = pdu_pkg::S_PT_SETUP;
        end
      end
      pdu_pkg::S_PT_SETUP: begin
        cnt_d   = '0;
        state_d = pdu_pkg::S_PT_MUL;
      end
      pdu_pkg::S_PT_MUL: begin
        if (cnt_q == MUL_LAST) state_d = pdu_pkg::S_PT_DIVI;
      end
      pdu_pkg::S_PT_DIVI: begin
        cnt_d   = '0;
        state_d = pdu_pkg::S_PT_DIV;
      end
      pdu_pkg::S_PT_DIV: begin
        if (cnt_q == ITER_LAST) state_d = pdu_pkg::S_PT_STORE;
      end
      pdu_pkg::S_PT_STORE: begin
        if (axis_q == AXIS_LAST) begin
          state_d = pdu_pkg::S_EMIT_PT;
        end else begin
          axis_d  = axis_q + 1'b1;
          state_d = pdu_pkg::S_PT_SETUP;
        end
      end
      pdu_pkg::S_EMIT_PT: begin
        if (sts_i.out_free) state_d = pdu_pkg::S_PT_CHK;
      end
      pdu_pkg::S_EMIT_VTX: begin
        if (sts_i.out_free) state_d = pdu_pkg::S_IDLE;
      end
      default: begin
        state_d = pdu_pkg::S_IDLE;
      end
    endcase
  end

  // Commands
  always_comb begin
    cmd_o      = '0;
    cmd_o.axis = axis_q;
    in_stall_o = 1'b1;
    case (state_q)
      pdu_pkg::S_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.load_in = in_valid_i;
      end
      pdu_pkg::S_DECIDE:    cmd_o.delta = 1'b1;
      pdu_pkg::S_SQ_SETUP: begin
        cmd_o.sq_setup = 1'b1;
        cmd_o.sq_clear = (axis_q == '0);
      end
      pdu_pkg::S_SQ_STEP:   cmd_o.mul_step  = 1'b1;
      pdu_pkg::S_SQRT_INIT: cmd_o.sqrt_init = 1'b1;
      pdu_pkg::S_SQRT_STEP: cmd_o.sqrt_step = 1'b1;
      pdu_pkg::S_N_CHK:     cmd_o.ndiv_init = !sts_i.skip_div;
      pdu_pkg::S_NDIV_STEP: cmd_o.div_step  = 1'b1;
      pdu_pkg::S_NSET:      cmd_o.nset      = 1'b1;
      pdu_pkg::S_PT_CHK:    cmd_o.m_adv     = (j_q != sts_i.n);
      pdu_pkg::S_PT_SETUP:  cmd_o.pt_setup  = 1'b1;
      pdu_pkg::S_PT_MUL:    cmd_o.mul_step  = 1'b1;
      pdu_pkg::S_PT_DIVI:   cmd_o.pt_div_init = 1'b1;
      pdu_pkg::S_PT_DIV:    cmd_o.div_step  = 1'b1;
      pdu_pkg::S_PT_STORE:  cmd_o.pt_store  = 1'b1;
      pdu_pkg::S_EMIT_PT:   cmd_o.emit_pt   = sts_i.out_free;
      pdu_pkg::S_EMIT_VTX:  cmd_o.emit_vtx  = sts_i.out_free;
      default:              cmd_o.axis      = axis_q;
    endcase
  end

  // Checks
  a_emit_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit_pt || cmd_o.emit_vtx) |-> sts_i.out_free)
    else $error("result emitted while output register occupied");

  a_accept_decide : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == pdu_pkg::S_DECIDE))
    else $error("accepted vertex not followed by decision step");

  a_j_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    j_q <= sts_i.n)
    else $error("point counter ran past insert count");

endmodule

`default_nettype wire

// ===== design/pdu_dpath.sv =====
// ----------------------------------------------------------------------------
// pdu_dpath
// Datapath of the densify unit: vertex registers, shift-add multiplier,
// digit-by-digit square root, restoring divider and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pdu_dpath #(
  parameter int unsigned COORD_BITS = pdu_pkg::COORD_BITS_DEF,
  parameter int unsigned MAX_INSERT = pdu_pkg::MAX_INSERT_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  pdu_pkg::dp_cmd_t                  cmd_i,
  output pdu_pkg::dp_sts_t                  sts_o,
  input  wire logic signed [COORD_BITS-1:0] in_x_i,
  input  wire logic signed [COORD_BITS-1:0] in_y_i,
  input  wire logic signed [COORD_BITS-1:0] in_z_i,
  input  wire logic                         line_start_i,
  input  wire logic                         cfg_valid_i,
  input  wire logic [pdu_pkg::SPC_W-1:0]    cfg_data_i,
  input  wire logic                         out_stall_i,
  output logic                              out_valid_o,
  output logic signed [COORD_BITS-1:0]      out_x_o,
  output logic signed [COORD_BITS-1:0]      out_y_o,
  output logic signed [COORD_BITS-1:0]      out_z_o,
  output logic                              inserted_o,
  output logic                              capped_o,
  output logic                              run_end_o
);

  localparam int unsigned C  = COORD_BITS;
  localparam int unsigned W  = C + 1;
  localparam int unsigned AW = 2 * W + 2;
  localparam int unsigned SW = 2 * W;
  localparam int unsigned DW = (W + 1 > pdu_pkg::SPC_W) ? W + 1 : pdu_pkg::SPC_W;
  localparam int unsigned RW = DW + 1;
  localparam int unsigned NW = pdu_pkg::N_W;

  // Vertex state
  logic [C-1:0] cur_q  [3];
  logic [C-1:0] prev_q [3];
  logic [C-1:0] pt_q   [3];
  logic [W-1:0] mag_q  [3];
  logic         neg_q  [3];
  logic         start_q, have_prev_q;
  logic [pdu_pkg::SPC_W-1:0] spacing_q;

  // Arithmetic state
  logic [AW-1:0] acc_q, mcand_q;
  logic [W:0]    mplier_q;
  logic [SW-1:0] sq_src_q;
  logic [W+1:0]  sq_rem_q;
  logic [W-1:0]  sq_root_q;
  logic [W-1:0]  dvd_q;
  logic [RW-1:0] rem_q;
  logic [DW-1:0] div_q;
  logic [W-1:0]  m_q;
  logic [NW-1:0] n_q;
  logic          cap_q;

  // Output register
  logic         out_valid_q;
  logic [C-1:0] out_x_q, out_y_q, out_z_q;
  logic         out_ins_q, out_cap_q, out_end_q;

  // Combinational helpers
  logic [W-1:0]  d_w [3];
  logic [W+1:0]  sq_r, sq_trial;
  logic          sq_ge;
  logic [RW-1:0] dv_r2;
  logic          dv_ge;
  logic [DW-1:0] spc_ext;
  logic [W-1:0]  prev_w, pt_sum;
  logic          out_free;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_w[i] = {cur_q[i][C-1], cur_q[i]} - {prev_q[i][C-1], prev_q[i]};
    end
  end

  assign sq_r     = {sq_rem_q[W-1:0], sq_src_q[SW-1 -: 2]};
  assign sq_trial = {sq_root_q, 2'b01};
  assign sq_ge    = (sq_r >= sq_trial);

  assign dv_r2 = {rem_q[RW-2:0], dvd_q[W-1]};
  assign dv_ge = (dv_r2 >= {1'b0, div_q});

  assign spc_ext = DW'(spacing_q);
  assign prev_w  = {prev_q[cmd_i.axis][C-1], prev_q[cmd_i.axis]};
  assign pt_sum  = neg_q[cmd_i.axis] ? (prev_w - dvd_q) : (prev_w + dvd_q);

  assign out_free = !out_valid_q || !out_stall_i;

  // Status
  assign sts_o.first    = start_q || !have_prev_q;
  assign sts_o.skip_div = (sq_root_q == '0) || (spacing_q == '0);
  assign sts_o.out_free = out_free;
  assign sts_o.n        = n_q;

  // Configuration and control flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spacing_q   <= pdu_pkg::SPC_RESET;
      have_prev_q <= 1'b0;
      out_valid_q <= 1'b0;
      n_q         <= '0;
      cap_q       <= 1'b0;
    end else begin
      if (cfg_valid_i) spacing_q <= cfg_data_i;
      if (cmd_i.emit_vtx) have_prev_q <= 1'b1;
      if (cmd_i.emit_pt || cmd_i.emit_vtx) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.load_in) begin
        n_q   <= '0;
        cap_q <= 1'b0;
      end else if (cmd_i.nset) begin
        cap_q <= (dvd_q > W'(MAX_INSERT));
        n_q   <= (dvd_q > W'(MAX_INSERT)) ? NW'(MAX_INSERT) : dvd_q[NW-1:0];
      end
    end
  end

  // Vertex registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      cur_q[0] <= in_x_i;
      cur_q[1] <= in_y_i;
      cur_q[2] <= in_z_i;
      start_q  <= line_start_i;
    end
    if (cmd_i.delta) begin
      for (int i = 0; i < 3; i++) begin
        neg_q[i] <= d_w[i][W-1];
        mag_q[i] <= d_w[i][W-1] ? (W'(0) - d_w[i]) : d_w[i];
      end
    end
    if (cmd_i.emit_vtx) begin
      for (int i = 0; i < 3; i++) prev_q[i] <= cur_q[i];
    end
    if (cmd_i.pt_store) pt_q[cmd_i.axis] <= pt_sum[C-1:0];
  end

  // Shift-add multiplier with accumulation
  always_ff @(posedge clk_i) begin
    if (cmd_i.sq_setup) begin
      if (cmd_i.sq_clear) acc_q <= '0;
      mcand_q  <= AW'(mag_q[cmd_i.axis]);
      mplier_q <= {1'b0, mag_q[cmd_i.axis]};
    end else if (cmd_i.pt_setup) begin
      acc_q    <= AW'(sq_root_q);
      mcand_q  <= AW'(mag_q[cmd_i.axis]);
      mplier_q <= {m_q, 1'b0};
    end else if (cmd_i.mul_step) begin
      if (mplier_q[0]) acc_q <= acc_q + mcand_q;
      mcand_q  <= {mcand_q[AW-2:0], 1'b0};
      mplier_q <= {1'b0, mplier_q[W:1]};
    end
  end

  // Square root, two radicand bits per step
  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_init) begin
      sq_src_q  <= acc_q[SW-1:0];
      sq_rem_q  <= '0;
      sq_root_q <= '0;
    end else if (cmd_i.sqrt_step) begin
      sq_src_q  <= {sq_src_q[SW-3:0], 2'b00};
      sq_rem_q  <= sq_ge ? (sq_r - sq_trial) : sq_r;
      sq_root_q <= {sq_root_q[W-2:0], sq_ge};
    end
  end

  // Restoring divider, one quotient bit per step
  always_ff @(posedge clk_i) begin
    if (cmd_i.ndiv_init) begin
      dvd_q <= sq_root_q - W'(sq_rem_q == '0);
      rem_q <= '0;
      div_q <= spc_ext;
    end else if (cmd_i.pt_div_init) begin
      dvd_q <= acc_q[W-1:0];
      rem_q <= RW'(acc_q[AW-1:W]);
      div_q <= DW'({sq_root_q, 1'b0});
    end else if (cmd_i.div_step) begin
      rem_q <= dv_ge ? (dv_r2 - {1'b0, div_q}) : dv_r2;
      dvd_q <= {dvd_q[W-2:0], dv_ge};
    end
  end

  // Distance along the segment
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      m_q <= '0;
    end else if (cmd_i.m_adv) begin
      m_q <= m_q + spc_ext[W-1:0];
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_pt) begin
      out_x_q   <= pt_q[0];
      out_y_q   <= pt_q[1];
      out_z_q   <= pt_q[2];
      out_ins_q <= 1'b1;
      out_cap_q <= cap_q;
      out_end_q <= 1'b0;
    end else if (cmd_i.emit_vtx) begin
      out_x_q   <= cur_q[0];
      out_y_q   <= cur_q[1];
      out_z_q   <= cur_q[2];
      out_ins_q <= 1'b0;
      out_cap_q <= cap_q;
      out_end_q <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_x_o     = out_x_q;
  assign out_y_o     = out_y_q;
  assign out_z_o     = out_z_q;
  assign inserted_o  = out_ins_q;
  assign capped_o    = out_cap_q;
  assign run_end_o   = out_end_q;

  // Checks
  a_div_rem : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> (rem_q < {1'b0, div_q}))
    else $error("divider remainder not below divisor");

  a_out_drop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_q) |-> $past(!out_stall_i))
    else $error("output transaction dropped while stalled");

endmodule

`default_nettype wire
